FILE: hw/rtl/blsw_pkg.sv
`timescale 1ns / 1ps
// Package for the block-linear swizzle blit address generator.
// Holds the swizzle masks, register indexes and the traversal restart function.
// No dependencies.
package blsw_pkg;

  localparam int unsigned PIXEL_BITS_DEF = 32;
  localparam int unsigned PIX_PORT_W     = 32;
  localparam int unsigned CFG_W          = 16;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned OFS_W          = 32;
  localparam int unsigned CNT_W          = 16;

  localparam logic [OFS_W-1:0] Y_SWZ_MASK    = 32'h0000_07B4;
  localparam logic [OFS_W-1:0] X_SWZ_MASK    = ~Y_SWZ_MASK;
  // X swizzle of one padded tile row of 1280 pixels.
  localparam logic [OFS_W-1:0] TILE_ROW_INCR = 32'h0002_8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X    = 3'd0,
    REG_ORIGIN_Y    = 3'd1,
    REG_RECT_WIDTH  = 3'd2,
    REG_RECT_HEIGHT = 3'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [OFS_W-1:0] row_start;
    logic [OFS_W-1:0] y_ofs;
  } restart_t;

  // Swizzled start offsets of the rectangle origin. The X bits land on the
  // clear bits of the Y mask; only the low seven Y bits fit under the Y mask,
  // and the rest of origin_y selects the tile row.
  function automatic restart_t restart_calc(logic [CFG_W-1:0] ox, logic [CFG_W-1:0] oy);
    restart_t         r;
    logic [OFS_W-1:0] sx;
    logic [OFS_W-1:0] tile;
    sx = {9'b0, ox[15:4], 4'b0, ox[3], 2'b0, ox[2], 1'b0, ox[1:0]};
    tile = (OFS_W'(oy[15:7]) << 15) + (OFS_W'(oy[15:7]) << 17);
    r.row_start = sx + tile;
    r.y_ofs = {21'b0, oy[6:3], 1'b0, oy[2:1], 1'b0, oy[0], 2'b0};
    return r;
  endfunction

endpackage

FILE: hw/rtl/block_linear_swizzle_blit_addr.sv
`timescale 1ns / 1ps
// Top level of the block-linear swizzle blit address generator.
// Depends on blsw_pkg.
//
//   channel | signals                                        | direction
//   in      | in_valid, in_stall, in_pixel_in                | pixel beats in
//   out     | out_valid, out_stall, out_pixel_out,           | address beats out
//           | out_word_offset, out_last_pixel                |
//   cfg     | cfg_we, cfg_index, cfg_wdata                   | register writes
//
// One pixel beat is accepted per cycle unless stalled; its result is registered.
// The offset counters update in the cycle of acceptance, which sets that rate.
// A two-entry output stage (result register plus skid register) absorbs stalls;
// in_stall rises only while both entries are full.
// Synchronous active-low reset clears registers, counters and offsets.
// With a zero width or height a pixel beat is consumed without a result.
module block_linear_swizzle_blit_addr #(
  parameter int unsigned PIXEL_BITS = blsw_pkg::PIXEL_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [blsw_pkg::PIX_PORT_W-1:0]   in_pixel_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [blsw_pkg::PIX_PORT_W-1:0]   out_pixel_out,
  output logic [blsw_pkg::OFS_W:0]          out_word_offset,
  output logic                              out_last_pixel,
  input  logic                              cfg_we,
  input  logic [blsw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [blsw_pkg::CFG_W-1:0]        cfg_wdata
);
  import blsw_pkg::*;

  localparam int unsigned KEEP_W = (PIXEL_BITS < PIX_PORT_W) ? PIXEL_BITS : PIX_PORT_W;

  logic [CFG_W-1:0] origin_x_r, origin_y_r, width_r, height_r;
  logic [CFG_W-1:0] origin_x_nxt, origin_y_nxt, width_nxt, height_nxt;
  logic             cfg_hit;

  logic [OFS_W-1:0] row_start_r, x_ofs_r, y_ofs_r;
  logic [OFS_W-1:0] row_start_nxt, x_ofs_nxt, y_ofs_nxt;
  logic [CNT_W-1:0] col_cnt_r, row_cnt_r, col_cnt_nxt, row_cnt_nxt;

  restart_t rs_cfg, rs_cur;

  logic             accept, active, row_end, last;
  logic [OFS_W-1:0] x_inc, y_inc, row_start_adv;
  logic             y_wrap;

  logic              push, pop;
  logic              out_valid_r, skid_valid_r;
  logic              out_valid_nxt, skid_valid_nxt;
  logic              load_out, load_skid, out_from_skid;
  logic [KEEP_W-1:0] out_pix_r, skid_pix_r;
  logic [OFS_W:0]    out_ofs_r, skid_ofs_r;
  logic              out_last_r, skid_last_r;
  logic [KEEP_W-1:0] res_pix;
  logic [OFS_W:0]    res_ofs;

  always_comb begin
    origin_x_nxt = origin_x_r;
    origin_y_nxt = origin_y_r;
    width_nxt    = width_r;
    height_nxt   = height_r;
    cfg_hit      = 1'b0;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ORIGIN_X: begin
          origin_x_nxt = cfg_wdata;
          cfg_hit      = 1'b1;
        end
        REG_ORIGIN_Y: begin
          origin_y_nxt = cfg_wdata;
          cfg_hit      = 1'b1;
        end
        REG_RECT_WIDTH: begin
          width_nxt = cfg_wdata;
          cfg_hit   = 1'b1;
        end
        REG_RECT_HEIGHT: begin
          height_nxt = cfg_wdata;
          cfg_hit    = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  assign rs_cfg = restart_calc(origin_x_nxt, origin_y_nxt);
  assign rs_cur = restart_calc(origin_x_r, origin_y_r);

  assign accept        = in_valid && !in_stall;
  assign active        = (width_r != '0) && (height_r != '0);
  assign row_end       = (col_cnt_r == width_r - 1'b1);
  assign last          = row_end && (row_cnt_r == height_r - 1'b1);
  assign x_inc         = (x_ofs_r - X_SWZ_MASK) & X_SWZ_MASK;
  assign y_inc         = (y_ofs_r - Y_SWZ_MASK) & Y_SWZ_MASK;
  assign y_wrap        = (y_inc == '0);
  assign row_start_adv = row_start_r + TILE_ROW_INCR;

  always_comb begin
    row_start_nxt = row_start_r;
    x_ofs_nxt     = x_ofs_r;
    y_ofs_nxt     = y_ofs_r;
    col_cnt_nxt   = col_cnt_r;
    row_cnt_nxt   = row_cnt_r;
    if (cfg_hit) begin
      row_start_nxt = rs_cfg.row_start;
      x_ofs_nxt     = rs_cfg.row_start;
      y_ofs_nxt     = rs_cfg.y_ofs;
      col_cnt_nxt   = '0;
      row_cnt_nxt   = '0;
    end else if (accept && active) begin
      if (last) begin
        row_start_nxt = rs_cur.row_start;
        x_ofs_nxt     = rs_cur.row_start;
        y_ofs_nxt     = rs_cur.y_ofs;
        col_cnt_nxt   = '0;
        row_cnt_nxt   = '0;
      end else if (row_end) begin
        col_cnt_nxt   = '0;
        row_cnt_nxt   = row_cnt_r + 1'b1;
        y_ofs_nxt     = y_inc;
        row_start_nxt = y_wrap ? row_start_adv : row_start_r;
        x_ofs_nxt     = y_wrap ? row_start_adv : row_start_r;
      end else begin
        col_cnt_nxt = col_cnt_r + 1'b1;
        x_ofs_nxt   = x_inc;
      end
    end
  end

  assign res_pix = in_pixel_in[KEEP_W-1:0];
  assign res_ofs = {1'b0, y_ofs_r} + {1'b0, x_ofs_r};

  assign push = accept && active;
  assign pop  = out_valid_r && !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    load_out       = 1'b0;
    load_skid      = 1'b0;
    out_from_skid  = 1'b0;
    if (skid_valid_r) begin
      if (pop) begin
        out_from_skid  = 1'b1;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        load_out      = 1'b1;
        out_valid_nxt = 1'b1;
      end else begin
        load_skid      = 1'b1;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r   <= '0;
      origin_y_r   <= '0;
      width_r      <= '0;
      height_r     <= '0;
      row_start_r  <= '0;
      x_ofs_r      <= '0;
      y_ofs_r      <= '0;
      col_cnt_r    <= '0;
      row_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      origin_x_r   <= origin_x_nxt;
      origin_y_r   <= origin_y_nxt;
      width_r      <= width_nxt;
      height_r     <= height_nxt;
      row_start_r  <= row_start_nxt;
      x_ofs_r      <= x_ofs_nxt;
      y_ofs_r      <= y_ofs_nxt;
      col_cnt_r    <= col_cnt_nxt;
      row_cnt_r    <= row_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_from_skid) begin
      out_pix_r  <= skid_pix_r;
      out_ofs_r  <= skid_ofs_r;
      out_last_r <= skid_last_r;
    end else if (load_out) begin
      out_pix_r  <= res_pix;
      out_ofs_r  <= res_ofs;
      out_last_r <= last;
    end
    if (load_skid) begin
      skid_pix_r  <= res_pix;
      skid_ofs_r  <= res_ofs;
      skid_last_r <= last;
    end
  end

  assign in_stall        = skid_valid_r;
  assign out_valid       = out_valid_r;
  assign out_pixel_out   = PIX_PORT_W'(out_pix_r);
  assign out_word_offset = out_ofs_r;
  assign out_last_pixel  = out_last_r;

endmodule

FILE: hw/rtl/blsw_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the block-linear swizzle blit address generator.
// Depends on blsw_pkg; bound to block_linear_swizzle_blit_addr below.
module blsw_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [blsw_pkg::PIX_PORT_W-1:0]   out_pixel_out,
  input logic [blsw_pkg::OFS_W:0]          out_word_offset,
  input logic                              out_last_pixel
);
  import blsw_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output beat valid right after reset");

  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_out)
      && $stable(out_word_offset) && $stable(out_last_pixel))
    else $error("stalled output beat changed");

  a_stall_needs_full_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled while the output register is empty");

  a_stall_rise_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall && in_valid))
    else $error("input stall rose without a stalled output beat");

endmodule

bind block_linear_swizzle_blit_addr blsw_checker u_blsw_checker (.*);

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// Testbench for block_linear_swizzle_blit_addr: streams pixel beats through rectangles of
// varied origin and size and checks every address beat against a local swizzle model.
// Depends on blsw_pkg and the block's RTL.
module testbench;
  import blsw_pkg::*;

  localparam int unsigned CLK_PERIOD    = 12;
  localparam int unsigned TILE_ROWS     = 128;
  localparam int unsigned PADDED_PIXELS = 1280;
  localparam int unsigned NUM_REGS      = 4;
  localparam int unsigned TARGET_PIXELS = 800;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned MAX_GAP       = 11;
  localparam int unsigned LONG_HOLD     = 120;
  localparam logic [PIX_PORT_W-1:0] PIX_KEEP =
    PIX_PORT_W'((64'd1 << PIXEL_BITS_DEF) - 64'd1);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [PIX_PORT_W-1:0] pixel;
    logic [OFS_W:0]        offset;
    logic                  last;
  } addr_beat_t;

  typedef enum {SHAPE_EMPTY, SHAPE_TALL, SHAPE_HUGE, SHAPE_SMALL} rect_shape_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [PIX_PORT_W-1:0] in_pixel_in;
  logic                  out_valid;
  logic                  out_stall;
  logic [PIX_PORT_W-1:0] out_pixel_out;
  logic [OFS_W:0]        out_word_offset;
  logic                  out_last_pixel;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_wdata;

  logic [CFG_W-1:0] reg_ox, reg_oy, reg_w, reg_h;
  logic [OFS_W-1:0] row_start_ofs, x_ofs, y_ofs;
  logic [CNT_W-1:0] col_idx, row_idx;
  addr_beat_t       addr_beats_q[$];

  int mismatch_count  = 0;
  int stall_left      = 0;
  int hold_cycles_req = 0;
  bit gaps_on_in      = 1'b1;
  bit gaps_on_out     = 1'b1;

  block_linear_swizzle_blit_addr dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pixel_in     (in_pixel_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_out   (out_pixel_out),
    .out_word_offset (out_word_offset),
    .out_last_pixel  (out_last_pixel),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  function automatic logic [OFS_W-1:0] spread_bits(logic [OFS_W-1:0] mask, logic [OFS_W-1:0] v);
    logic [OFS_W-1:0] r;
    int               j;
    r = '0;
    j = 0;
    for (int i = 0; i < OFS_W; i++) begin
      if (mask[i]) begin
        r[i] = v[j];
        j++;
      end
    end
    return r;
  endfunction

  function automatic logic [OFS_W-1:0] tile_row_step();
    return spread_bits(X_SWZ_MASK, OFS_W'(PADDED_PIXELS));
  endfunction

  function automatic void restart_walk();
    row_start_ofs = spread_bits(X_SWZ_MASK, OFS_W'(reg_ox))
                    + tile_row_step() * OFS_W'(reg_oy / TILE_ROWS);
    x_ofs = row_start_ofs;
    y_ofs = spread_bits(Y_SWZ_MASK, OFS_W'(reg_oy));
    col_idx = '0;
    row_idx = '0;
  endfunction

  function automatic void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    case (idx)
      REG_ORIGIN_X:    reg_ox = val;
      REG_ORIGIN_Y:    reg_oy = val;
      REG_RECT_WIDTH:  reg_w = val;
      REG_RECT_HEIGHT: reg_h = val;
      default:         return;
    endcase
    restart_walk();
  endfunction

  function automatic void walk_pixel(logic [PIX_PORT_W-1:0] pix);
    addr_beat_t beat;
    if (reg_w == '0 || reg_h == '0) return;
    beat.pixel = pix & PIX_KEEP;
    beat.offset = {1'b0, y_ofs} + {1'b0, x_ofs};
    beat.last = (col_idx == reg_w - 1'b1) && (row_idx == reg_h - 1'b1);
    addr_beats_q.push_back(beat);
    if (beat.last) begin
      restart_walk();
      return;
    end
    x_ofs = (x_ofs - X_SWZ_MASK) & X_SWZ_MASK;
    col_idx = col_idx + 1'b1;
    if (col_idx == reg_w) begin
      col_idx = '0;
      y_ofs = (y_ofs - Y_SWZ_MASK) & Y_SWZ_MASK;
      if (y_ofs == '0) row_start_ofs = row_start_ofs + tile_row_step();
      x_ofs = row_start_ofs;
      row_idx = row_idx + 1'b1;
    end
  endfunction

  function automatic logic [CFG_W-1:0] pick_coord();
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return CFG_W'($urandom);
  endfunction

  function automatic logic [PIX_PORT_W-1:0] random_pixel();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return PIX_PORT_W'($urandom);
  endfunction

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles_req > 0) begin
        stall_left = hold_cycles_req;
        hold_cycles_req = 0;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    addr_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      stall_left = gaps_on_out ? int'($urandom_range(0, MAX_GAP)) : 0;
      if (addr_beats_q.size() == 0) begin
        $display("%0t: unexpected beat pixel %h offset %h last %b", $time,
                 out_pixel_out, out_word_offset, out_last_pixel);
        mismatch_count++;
      end else begin
        want = addr_beats_q.pop_front();
        if (out_pixel_out !== want.pixel) begin
          $display("%0t: pixel expected %h actual %h", $time, want.pixel, out_pixel_out);
          mismatch_count++;
        end
        if (out_word_offset !== want.offset) begin
          $display("%0t: word offset expected %h actual %h", $time, want.offset,
                   out_word_offset);
          mismatch_count++;
        end
        if (out_last_pixel !== want.last) begin
          $display("%0t: last pixel expected %b actual %b", $time, want.last,
                   out_last_pixel);
          mismatch_count++;
        end
      end
    end
  end

  task automatic send_pixel(input logic [PIX_PORT_W-1:0] pix);
    int gap;
    gap = gaps_on_in ? int'($urandom_range(0, MAX_GAP)) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_in <= pix;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    walk_pixel(pix);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (addr_beats_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    set_reg(idx, val);
  endtask

  task automatic program_rect(input logic [CFG_W-1:0] ox, oy, w, h);
    logic [CFG_W-1:0] vals[NUM_REGS];
    int               first;
    vals = '{ox, oy, w, h};
    first = $urandom_range(0, NUM_REGS - 1);
    drain();
    for (int k = 0; k < NUM_REGS; k++) begin
      write_reg(CFG_IDX_W'((first + k) % NUM_REGS), vals[(first + k) % NUM_REGS]);
    end
  endtask

  task automatic test_empty_after_reset();
    send_pixel('0);
    send_pixel('1);
    send_pixel(random_pixel());
  endtask

  task automatic test_corner_rectangles();
    program_rect('0, '0, 16'd1, 16'd1);
    send_pixel('0);
    send_pixel('1);
    program_rect('1, '1, 16'd3, 16'd2);
    repeat (7) send_pixel(random_pixel());
    program_rect('1, '0, '1, '1);
    repeat (3) send_pixel(random_pixel());
    program_rect(pick_coord(), pick_coord(), 16'd5, '0);
    repeat (2) send_pixel(random_pixel());
    program_rect(pick_coord(), pick_coord(), '0, 16'd4);
    send_pixel(random_pixel());
  endtask

  task automatic test_spare_index();
    program_rect(pick_coord(), pick_coord(), 16'd3, 16'd2);
    repeat (2) send_pixel(random_pixel());
    drain();
    write_reg(REG_SPARE_LO, CFG_W'($urandom));
    write_reg(REG_SPARE_HI, CFG_W'($urandom));
    repeat (4) send_pixel(random_pixel());
  endtask

  task automatic test_backpressure();
    gaps_on_in = 1'b0;
    gaps_on_out = 1'b1;
    program_rect(pick_coord(), {CFG_W'($urandom) & 16'hFF80} | 16'd124, 16'd6, 16'd4);
    @(posedge clk);
    hold_cycles_req = LONG_HOLD;
    repeat (30) send_pixel(random_pixel());
  endtask

  task automatic test_random_rectangles();
    longint unsigned  sent;
    longint unsigned  area;
    int               n;
    int unsigned      pick;
    rect_shape_t      shape;
    logic [CFG_W-1:0] ox, oy, w, h;
    sent = 0;
    while (sent < TARGET_PIXELS) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) shape = SHAPE_EMPTY;
      else if (pick <= 2) shape = SHAPE_TALL;
      else if (pick == 3) shape = SHAPE_HUGE;
      else shape = SHAPE_SMALL;
      ox = pick_coord();
      oy = pick_coord();
      case (shape)
        SHAPE_EMPTY: begin
          if ($urandom_range(0, 1) == 0) begin
            w = '0;
            h = pick_coord();
          end else begin
            w = pick_coord();
            h = '0;
          end
        end
        SHAPE_TALL: begin
          w = CFG_W'($urandom_range(1, 2));
          oy[6:0] = 7'($urandom_range(110, 127));
          h = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(129, 150))
                                          : CFG_W'($urandom_range(10, 40));
        end
        SHAPE_HUGE: begin
          w = CFG_W'($urandom_range(1000, 65535));
          h = CFG_W'($urandom_range(1, 65535));
        end
        default: begin
          w = CFG_W'($urandom_range(1, 12));
          h = CFG_W'($urandom_range(1, 10));
        end
      endcase
      gaps_on_in = ($urandom_range(0, 3) != 0);
      gaps_on_out = ($urandom_range(0, 3) != 0);
      program_rect(ox, oy, w, h);
      area = longint'(w) * longint'(h);
      if (area == 0) begin
        n = $urandom_range(1, 5);
      end else if (shape == SHAPE_HUGE) begin
        n = $urandom_range(20, 60);
      end else begin
        n = int'(area) + int'($urandom_range(0, int'(area)));
        if (n > 320) n = 320;
      end
      repeat (n) send_pixel(random_pixel());
      if (area != 0) sent += n;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pixel_in = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    reg_ox = '0;
    reg_oy = '0;
    reg_w = '0;
    reg_h = '0;
    restart_walk();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    test_empty_after_reset();
    test_corner_rectangles();
    test_spare_index();
    test_backpressure();
    test_random_rectangles();
    drain();
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/blsw_pkg.sv
hw/rtl/block_linear_swizzle_blit_addr.sv
hw/rtl/blsw_checker.sv
bench/testbench.sv
